// File: rtl/core/bounded_undo_redo_history_defines.svh
// Assertion macros for the bounded undo/redo history.
// Used by the checker module; no other dependencies.
`ifndef BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH
`define BOUNDED_UNDO_REDO_HISTORY_DEFINES_SVH

// Check on every rising clock edge, off while reset is asserted.
`define BUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define BUR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/bur_pkg.sv
// Shared types and constants of the bounded undo/redo history.
// No dependencies; imported by the cell, the top level and the checker.
package bur_pkg;

  localparam int unsigned BUR_DEPTH        = 64;
  localparam int unsigned BUR_HANDLE_WIDTH = 64;
  localparam int unsigned SNAP_W           = 64;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned KIND_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RESET = 2'd0,
    OP_PUSH  = 2'd1,
    OP_UNDO  = 2'd2,
    OP_REDO  = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_SNAP  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_IN   = 2'd1,
    SH_OUT  = 2'd2
  } shift_e;

  typedef struct packed {
    shift_e undo_sh;
    shift_e redo_sh;
  } cell_ctl_t;

endpackage

// File: rtl/core/bur_cell.sv
// One history cell: a slot of the undo chain and a slot of the redo chain.
// Depends on bur_pkg for the shift control struct.
module bur_cell import bur_pkg::*; #(
  parameter int unsigned HW = BUR_HANDLE_WIDTH
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [HW-1:0] undo_prev_i,
  input  logic [HW-1:0] undo_next_i,
  input  logic [HW-1:0] redo_prev_i,
  input  logic [HW-1:0] redo_next_i,
  output logic [HW-1:0] undo_o,
  output logic [HW-1:0] redo_o
);

  logic [HW-1:0] undo_q, undo_d;
  logic [HW-1:0] redo_q, redo_d;

  always_comb begin
    case (ctl_i.undo_sh)
      SH_IN:   undo_d = undo_prev_i;
      SH_OUT:  undo_d = undo_next_i;
      default: undo_d = undo_q;
    endcase
    case (ctl_i.redo_sh)
      SH_IN:   redo_d = redo_prev_i;
      SH_OUT:  redo_d = redo_next_i;
      default: redo_d = redo_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    undo_q <= undo_d;
    redo_q <= redo_d;
  end

  assign undo_o = undo_q;
  assign redo_o = redo_q;

endmodule

// File: rtl/core/bounded_undo_redo_history.sv
// Top level of the bounded undo/redo history: control, counters, cell chain.
// Depends on bur_pkg and bur_cell.
//
// Usage:
//   Drive operation_i, snapshot_i and base_present_i with start_i high; the
//   transaction is taken at that rising edge whenever busy_o is low. busy_o
//   stays low, so one transaction may be issued every cycle.
//   Each transaction returns exactly one result in the next cycle: done_o is
//   high for that single cycle with kind_o, snapshot_out_o, can_undo_o and
//   can_redo_o. The receiver cannot stall; results must be taken on the spot.
//   Throughput 1 transaction per cycle, set by the cell chain: every operation
//   moves the undo and redo chains by at most one cell and reads only cells 0
//   and 1 of the undo chain and cell 0 of the redo chain.
//   The undo chain holds the steps up to the cursor, newest at cell 0; the
//   redo chain holds the steps past the cursor, nearest at cell 0. A push into
//   a full history drops the oldest step off the tail of the undo chain.
//   Reset (rst_ni low) empties the history and clears done_o; the cells keep
//   their contents, which are never read before they are written again.
module bounded_undo_redo_history import bur_pkg::*; #(
  parameter int unsigned DEPTH        = BUR_DEPTH,
  parameter int unsigned HANDLE_WIDTH = BUR_HANDLE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [SNAP_W-1:0] snapshot_i,
  input  logic              base_present_i,
  output logic              done_o,
  output logic [KIND_W-1:0] kind_o,
  output logic [SNAP_W-1:0] snapshot_out_o,
  output logic              can_undo_o,
  output logic              can_redo_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned HW = HANDLE_WIDTH;

  logic [CW-1:0] undo_cnt_q, undo_cnt_d;
  logic [CW-1:0] redo_cnt_q, redo_cnt_d;
  logic          done_q;
  kind_e         kind_q, kind_d;
  logic [HW-1:0] snap_q, snap_d;
  logic          can_undo_q, can_redo_q;

  logic          accept;
  op_e           op;
  logic [HW-1:0] handle;
  cell_ctl_t     ctl;
  logic [HW-1:0] undo_head_in, redo_head_in;
  logic [HW-1:0] undo_cell [DEPTH];
  logic [HW-1:0] redo_cell [DEPTH];

  assign accept = start_i && !busy_o;
  assign op     = op_e'(operation_i);
  assign handle = snapshot_i[HW-1:0];
  assign busy_o = 1'b0;

  always_comb begin
    undo_cnt_d   = undo_cnt_q;
    redo_cnt_d   = redo_cnt_q;
    ctl.undo_sh  = SH_HOLD;
    ctl.redo_sh  = SH_HOLD;
    kind_d       = KIND_NONE;
    snap_d       = '0;
    undo_head_in = handle;
    redo_head_in = undo_cell[0];
    if (accept) begin
      case (op)
        OP_RESET: begin
          redo_cnt_d = '0;
          if (base_present_i) begin
            undo_cnt_d  = CW'(1);
            ctl.undo_sh = SH_IN;
          end else begin
            undo_cnt_d = '0;
          end
        end
        OP_PUSH: begin
          redo_cnt_d  = '0;
          ctl.undo_sh = SH_IN;
          if (undo_cnt_q != CW'(DEPTH)) begin
            undo_cnt_d = undo_cnt_q + CW'(1);
          end
        end
        OP_UNDO: begin
          if (undo_cnt_q != '0) begin
            undo_cnt_d  = undo_cnt_q - CW'(1);
            redo_cnt_d  = redo_cnt_q + CW'(1);
            ctl.undo_sh = SH_OUT;
            ctl.redo_sh = SH_IN;
            if (undo_cnt_q == CW'(1)) begin
              kind_d = KIND_EMPTY;
            end else begin
              kind_d = KIND_SNAP;
              snap_d = undo_cell[1];
            end
          end
        end
        OP_REDO: begin
          undo_head_in = redo_cell[0];
          if (redo_cnt_q != '0) begin
            undo_cnt_d  = undo_cnt_q + CW'(1);
            redo_cnt_d  = redo_cnt_q - CW'(1);
            ctl.undo_sh = SH_IN;
            ctl.redo_sh = SH_OUT;
            kind_d      = KIND_SNAP;
            snap_d      = redo_cell[0];
          end
        end
        default: begin
          kind_d = KIND_NONE;
        end
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [HW-1:0] undo_prev, undo_next, redo_prev, redo_next;
    if (k == 0) begin : g_head
      assign undo_prev = undo_head_in;
      assign redo_prev = redo_head_in;
    end else begin : g_body
      assign undo_prev = undo_cell[k-1];
      assign redo_prev = redo_cell[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign undo_next = undo_cell[k];
      assign redo_next = redo_cell[k];
    end else begin : g_link
      assign undo_next = undo_cell[k+1];
      assign redo_next = redo_cell[k+1];
    end
    bur_cell #(
      .HW (HW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .undo_prev_i (undo_prev),
      .undo_next_i (undo_next),
      .redo_prev_i (redo_prev),
      .redo_next_i (redo_next),
      .undo_o      (undo_cell[k]),
      .redo_o      (redo_cell[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      undo_cnt_q <= '0;
      redo_cnt_q <= '0;
      done_q     <= 1'b0;
      can_undo_q <= 1'b0;
      can_redo_q <= 1'b0;
    end else begin
      undo_cnt_q <= undo_cnt_d;
      redo_cnt_q <= redo_cnt_d;
      done_q     <= accept;
      can_undo_q <= (undo_cnt_d != '0);
      can_redo_q <= (redo_cnt_d != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    snap_q <= snap_d;
  end

  assign done_o         = done_q;
  assign kind_o         = kind_q;
  assign snapshot_out_o = SNAP_W'(snap_q);
  assign can_undo_o     = can_undo_q;
  assign can_redo_o     = can_redo_q;

endmodule

// File: rtl/core/bur_checker.sv
// Port-level assertions for the bounded undo/redo history, bound to the top.
// Depends on bur_pkg and bounded_undo_redo_history_defines.svh.
`include "bounded_undo_redo_history_defines.svh"

module bur_checker import bur_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [OP_W-1:0]   operation_i,
  input logic              done_o,
  input logic [KIND_W-1:0] kind_o,
  input logic [SNAP_W-1:0] snapshot_out_o,
  input logic              can_undo_o,
  input logic              can_redo_o
);

  logic take;
  assign take = start_i && !busy_o;

  `BUR_ASSERT(a_result_follows, take |=> done_o, "transaction without a result")
  `BUR_ASSERT(a_no_spurious, !take |=> !done_o, "result without a transaction")
  `BUR_ASSERT(a_zero_handle, (done_o && kind_o != KIND_SNAP) |-> (snapshot_out_o == '0), "stray handle")
  `BUR_ASSERT(a_empty_flags, (done_o && kind_o == KIND_EMPTY) |-> (!can_undo_o && can_redo_o), "bad flags after empty marker")
  `BUR_ASSERT(a_push_result, (take && operation_i == OP_PUSH) |=> (kind_o == KIND_NONE && can_undo_o && !can_redo_o), "bad push result")

endmodule

bind bounded_undo_redo_history bur_checker u_bur_checker (.*);

// File: tb/tb_bounded_undo_redo_history.sv
// Self-checking testbench for bounded_undo_redo_history: directed, ring wrap and random tests.
// Predicts every result from its own history model; depends on bur_pkg and the RTL top level.
module tb_bounded_undo_redo_history;
  import bur_pkg::*;

  localparam int DEPTH = BUR_DEPTH;
  localparam int IDX_W = $clog2(BUR_DEPTH);
  localparam logic [SNAP_W-1:0] HANDLE_MASK = {SNAP_W{1'b1}} >> (SNAP_W - BUR_HANDLE_WIDTH);
  localparam int ITEM_TARGET = 1750;
  localparam int DRAIN_EVERY = 250;
  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    kind_e             kind;
    logic [SNAP_W-1:0] handle;
    logic              undo_ok;
    logic              redo_ok;
  } history_result_t;

  typedef enum {MIX_FILL, MIX_PUSH, MIX_UNDO, MIX_REDO, MIX_EVEN} op_mix_e;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [OP_W-1:0]   operation_i = OP_RESET;
  logic [SNAP_W-1:0] snapshot_i = '0;
  logic              base_present_i = 1'b0;
  logic              done_o;
  logic [KIND_W-1:0] kind_o;
  logic [SNAP_W-1:0] snapshot_out_o;
  logic              can_undo_o;
  logic              can_redo_o;

  logic [SNAP_W-1:0] ring_store [DEPTH];
  int                ring_base = 0;
  int                step_count = 0;
  int                cursor = -1;

  history_result_t   results_due [$];
  history_result_t   want_res;
  int                mismatches = 0;
  int                ops_issued = 0;
  int                idle_cycles = 0;
  bit                no_idle = 1'b0;

  bounded_undo_redo_history #(
    .DEPTH        (BUR_DEPTH),
    .HANDLE_WIDTH (BUR_HANDLE_WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .snapshot_i     (snapshot_i),
    .base_present_i (base_present_i),
    .done_o         (done_o),
    .kind_o         (kind_o),
    .snapshot_out_o (snapshot_out_o),
    .can_undo_o     (can_undo_o),
    .can_redo_o     (can_redo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [IDX_W-1:0] slot_of(int step);
    return IDX_W'((ring_base + step) % DEPTH);
  endfunction

  function automatic history_result_t predict_history(op_e op, logic [SNAP_W-1:0] snap,
                                                     logic base);
    history_result_t res;
    logic [SNAP_W-1:0] h;
    h = snap & HANDLE_MASK;
    res.kind = KIND_NONE;
    res.handle = '0;
    case (op)
      OP_RESET: begin
        ring_base = 0;
        if (base) begin
          ring_store[0] = h;
          step_count = 1;
          cursor = 0;
        end else begin
          step_count = 0;
          cursor = -1;
        end
      end
      OP_PUSH: begin
        if (cursor >= DEPTH - 1) begin
          ring_store[IDX_W'(ring_base)] = h;
          ring_base = (ring_base + 1) % DEPTH;
          step_count = DEPTH;
          cursor = DEPTH - 1;
        end else begin
          cursor = cursor + 1;
          ring_store[slot_of(cursor)] = h;
          step_count = cursor + 1;
        end
      end
      OP_UNDO: begin
        if (cursor > 0) begin
          cursor = cursor - 1;
          res.kind = KIND_SNAP;
          res.handle = ring_store[slot_of(cursor)];
        end else if (cursor == 0) begin
          cursor = -1;
          res.kind = KIND_EMPTY;
        end
      end
      default: begin
        if (cursor < step_count - 1) begin
          cursor = cursor + 1;
          res.kind = KIND_SNAP;
          res.handle = ring_store[slot_of(cursor)];
        end
      end
    endcase
    res.undo_ok = (cursor >= 0);
    res.redo_ok = (cursor < step_count - 1);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SNAP_W-1:0] pick_handle();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return {{(SNAP_W-1){1'b0}}, 1'b1} << $urandom_range(0, SNAP_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic op_e pick_op(op_mix_e mix);
    int r;
    int push_pct;
    int undo_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin push_pct = 93; undo_pct = 3; end
      MIX_PUSH: begin push_pct = 65; undo_pct = 20; end
      MIX_UNDO: begin push_pct = 20; undo_pct = 65; end
      MIX_REDO: begin push_pct = 15; undo_pct = 30; end
      default:  begin push_pct = 33; undo_pct = 33; end
    endcase
    if (r < 1) return OP_RESET;
    if (r < 1 + push_pct) return OP_PUSH;
    if (r < 1 + push_pct + undo_pct) return OP_UNDO;
    return OP_REDO;
  endfunction

  task automatic report_mismatch(string what, logic [SNAP_W-1:0] want, logic [SNAP_W-1:0] got);
    $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic issue_op(op_e op, logic [SNAP_W-1:0] snap, logic base);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    snapshot_i     <= snap;
    base_present_i <= base;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    results_due.insert(results_due.size(), predict_history(op, snap, base));
    ops_issued++;
  endtask

  // hold off until every outstanding transaction has returned
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_edge_cases();
    issue_op(OP_UNDO, pick_handle(), 1'b1);
    issue_op(OP_REDO, pick_handle(), 1'b0);
    issue_op(OP_PUSH, '0, 1'b0);
    issue_op(OP_PUSH, '1, 1'b1);
    issue_op(OP_PUSH, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);
    issue_op(OP_REDO, pick_handle(), 1'b1);
    issue_op(OP_UNDO, pick_handle(), 1'b0);
    issue_op(OP_UNDO, pick_handle(), 1'b1);
    issue_op(OP_UNDO, pick_handle(), 1'b0);
    issue_op(OP_UNDO, pick_handle(), 1'b1);
    issue_op(OP_REDO, pick_handle(), 1'b0);
    issue_op(OP_REDO, pick_handle(), 1'b1);
    issue_op(OP_UNDO, pick_handle(), 1'b0);
    issue_op(OP_PUSH, 64'h0123_4567_89AB_CDEF, 1'b1);
    issue_op(OP_REDO, pick_handle(), 1'b0);
    issue_op(OP_RESET, 64'h8000_0000_0000_0000, 1'b1);
    issue_op(OP_UNDO, pick_handle(), 1'b0);
    issue_op(OP_REDO, pick_handle(), 1'b1);
    issue_op(OP_RESET, '1, 1'b0);
    issue_op(OP_UNDO, pick_handle(), 1'b1);
    issue_op(OP_REDO, pick_handle(), 1'b0);
    issue_op(OP_RESET, '1, 1'b1);
    issue_op(OP_PUSH, pick_handle(), 1'b0);
    issue_op(OP_UNDO, pick_handle(), 1'b0);
    issue_op(OP_REDO, pick_handle(), 1'b1);
  endtask

  task automatic test_ring_wrap();
    int i;
    issue_op(OP_RESET, pick_handle(), 1'b0);
    for (i = 0; i < DEPTH + 5; i++) issue_op(OP_PUSH, pick_handle(), 1'($urandom_range(0, 1)));
    issue_op(OP_REDO, pick_handle(), 1'b0);
    for (i = 0; i < DEPTH + 1; i++) issue_op(OP_UNDO, pick_handle(), 1'($urandom_range(0, 1)));
    for (i = 0; i < DEPTH + 1; i++) issue_op(OP_REDO, pick_handle(), 1'($urandom_range(0, 1)));
    issue_op(OP_PUSH, pick_handle(), 1'b1);
  endtask

  task automatic test_random_history();
    op_mix_e mix;
    op_e     op;
    int      len;
    int      i;
    int      next_drain;
    next_drain = ops_issued + DRAIN_EVERY;
    while (ops_issued < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0: mix = MIX_FILL;
        1: mix = MIX_PUSH;
        2: mix = MIX_UNDO;
        3: mix = MIX_REDO;
        default: mix = MIX_EVEN;
      endcase
      len = (mix == MIX_FILL) ? $urandom_range(40, 90) : $urandom_range(10, 120);
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
        op = pick_op(mix);
        issue_op(op, pick_handle(), 1'($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
      if (ops_issued >= next_drain) begin
        drain_results();
        next_drain = ops_issued + DRAIN_EVERY;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, kind", '0, SNAP_W'(kind_o));
      end else begin
        want_res = results_due.pop_front();
        if (kind_o !== want_res.kind)
          report_mismatch("kind", SNAP_W'(want_res.kind), SNAP_W'(kind_o));
        if (snapshot_out_o !== want_res.handle)
          report_mismatch("snapshot_out", want_res.handle, snapshot_out_o);
        if (can_undo_o !== want_res.undo_ok)
          report_mismatch("can_undo", SNAP_W'(want_res.undo_ok), SNAP_W'(can_undo_o));
        if (can_redo_o !== want_res.redo_ok)
          report_mismatch("can_redo", SNAP_W'(want_res.redo_ok), SNAP_W'(can_redo_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && busy_o === 1'b0) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_cases();
    drain_results();
    test_ring_wrap();
    drain_results();
    test_random_history();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
